// ===== hw/rtl/fdt_pkg.sv =====
`default_nettype none

package fdt_pkg;

  // default operand width for n and a
  localparam int VALUE_BITS_DEF = 31;

endpackage

`default_nettype wire

// ===== hw/rtl/fdt_in_if.sv =====
`default_nettype none

// input channel: n and the candidate divisor a
interface fdt_in_if #(
  parameter int VALUE_BITS = fdt_pkg::VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] factorial_base;
  logic [VALUE_BITS-1:0] divisor_value;

  modport source (output valid, output factorial_base, output divisor_value, input ready);
  modport sink   (input valid, input factorial_base, input divisor_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fdt_out_if.sv =====
`default_nettype none

// result channel: one flag per transaction
interface fdt_out_if ();
  logic valid;
  logic ready;
  logic divides_flag;

  modport source (output valid, output divides_flag, input ready);
  modport sink   (input valid, input divides_flag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fdt_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle, divisor must be nonzero
module fdt_div #(
  parameter int VALUE_BITS = fdt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [VALUE_BITS-1:0]      remainder
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] den_r;

  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;

  // one restoring step
  always_comb begin
    shifted = {rem_r, quo_r[VALUE_BITS-1]};
    diff    = shifted - {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
      rem_r <= diff[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/factorial_divisibility_test_core.sv =====
`default_nettype none

// timing: when a is 0 or a <= n the sequencer goes straight to the finish state, and out
//   valid is registered from there once the output register is free; otherwise each step
//   is a division on the shared divider, one division per trial candidate, per exponent
//   step and per Legendre term, and the result is then loaded from the finish state
// throughput: one transaction at a time, the next is taken once the sequencer is idle
// reset: synchronous active-low rst_n clears the sequencer, divider and output valid
module factorial_divisibility_test_core #(
  parameter int VALUE_BITS = fdt_pkg::VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fdt_in_if.sink    in_chan,
  fdt_out_if.source out_chan
);

  localparam int EW = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TRY_W = 3'd1;
  localparam logic [2:0] ST_EXP_W = 3'd2;
  localparam logic [2:0] ST_LEG_W = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] rest_r, rest_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [VALUE_BITS-1:0] p_r, p_nxt;
  logic [VALUE_BITS-1:0] sum_r, sum_nxt;
  logic [EW-1:0]         e_r, e_nxt;
  logic                  last_r, last_nxt;
  logic                  flag_r, flag_nxt;
  logic                  out_valid_r;
  logic                  out_flag_r;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_num;
  logic [VALUE_BITS-1:0] div_den;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  logic [VALUE_BITS-1:0] d_next;
  logic [VALUE_BITS:0]   sum_add;
  logic                  fits;
  logic                  leg_end;

  fdt_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_chan.ready = (state_r == ST_IDLE);

  // next trial candidate: 2, then odd numbers
  assign d_next  = (d_r == VALUE_BITS'(2)) ? VALUE_BITS'(3) : d_r + VALUE_BITS'(2);
  // running Legendre sum with the new term
  assign sum_add = {1'b0, sum_r} + {1'b0, div_quo};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    rest_nxt  = rest_r;
    d_nxt     = d_r;
    p_nxt     = p_r;
    sum_nxt   = sum_r;
    e_nxt     = e_r;
    last_nxt  = last_r;
    flag_nxt  = flag_r;
    div_start = 1'b0;
    div_num   = rest_r;
    div_den   = d_r;
    fits      = 1'b0;
    leg_end   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          n_nxt = in_chan.factorial_base;
          if (in_chan.divisor_value == '0) begin
            flag_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else if (in_chan.divisor_value <= in_chan.factorial_base) begin
            flag_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            rest_nxt  = in_chan.divisor_value;
            d_nxt     = VALUE_BITS'(2);
            div_start = 1'b1;
            div_num   = in_chan.divisor_value;
            div_den   = VALUE_BITS'(2);
            state_nxt = ST_TRY_W;
          end
        end
      end
      ST_TRY_W: begin
        if (div_done) begin
          if (div_quo < d_r) begin
            // candidate past the square root of what is left
            if (rest_r > VALUE_BITS'(1)) begin
              p_nxt     = rest_r;
              e_nxt     = EW'(1);
              last_nxt  = 1'b1;
              sum_nxt   = '0;
              div_start = 1'b1;
              div_num   = n_r;
              div_den   = rest_r;
              state_nxt = ST_LEG_W;
            end else begin
              flag_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end
          end else if (div_rem == '0) begin
            rest_nxt  = div_quo;
            e_nxt     = EW'(1);
            div_start = 1'b1;
            div_num   = div_quo;
            div_den   = d_r;
            state_nxt = ST_EXP_W;
          end else begin
            d_nxt     = d_next;
            div_start = 1'b1;
            div_num   = rest_r;
            div_den   = d_next;
          end
        end
      end
      ST_EXP_W: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest_nxt  = div_quo;
            e_nxt     = e_r + EW'(1);
            div_start = 1'b1;
            div_num   = div_quo;
            div_den   = d_r;
          end else begin
            p_nxt     = d_r;
            last_nxt  = 1'b0;
            sum_nxt   = '0;
            div_start = 1'b1;
            div_num   = n_r;
            div_den   = d_r;
            state_nxt = ST_LEG_W;
          end
        end
      end
      ST_LEG_W: begin
        if (div_done) begin
          if (div_quo == '0) begin
            leg_end = 1'b1;
            fits    = ({1'b0, sum_r} >= (VALUE_BITS + 1)'(e_r));
          end else if (sum_add >= (VALUE_BITS + 1)'(e_r)) begin
            leg_end = 1'b1;
            fits    = 1'b1;
          end else begin
            sum_nxt   = sum_add[VALUE_BITS-1:0];
            div_start = 1'b1;
            div_num   = div_quo;
            div_den   = p_r;
          end
          if (leg_end) begin
            if (!fits) begin
              flag_nxt  = 1'b0;
              state_nxt = ST_FIN;
            end else if (last_r) begin
              flag_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              d_nxt     = d_next;
              div_start = 1'b1;
              div_num   = rest_r;
              div_den   = d_next;
              state_nxt = ST_TRY_W;
            end
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rest_r <= rest_nxt;
    d_r    <= d_nxt;
    p_r    <= p_nxt;
    sum_r  <= sum_nxt;
    e_r    <= e_nxt;
    last_r <= last_nxt;
    flag_r <= flag_nxt;
    if (state_r == ST_FIN && (!out_valid_r || out_chan.ready)) begin
      out_flag_r <= flag_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.divides_flag = out_flag_r;

endmodule

`default_nettype wire

// ===== test/factorial_divisibility_test_core_tb.sv =====
`default_nettype none

module factorial_divisibility_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = fdt_pkg::VALUE_BITS_DEF;
  localparam logic [VB-1:0] MAX_VAL = {VB{1'b1}};
  localparam logic [VB-1:0] TOP_BIT = {1'b1, {(VB - 1){1'b0}}};
  // longest correct gap between transactions is one full trial division of a
  // large prime; the limit here is several times that
  localparam int STALL_LIMIT = 8_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 26;

  // expected flags and the checks against them
  class divisibility_scoreboard;
    bit expected_flags[$];
    int failures;

    // true when n! holds at least e factors of the prime p
    static function bit prime_count_reaches(longint unsigned n, longint unsigned p,
                                            longint unsigned e);
      longint unsigned q;
      longint unsigned total;
      q = n / p;
      total = 0;
      while (q != 0 && total < e) begin
        total += q;
        q = q / p;
      end
      return total >= e;
    endfunction

    static function bit divides_factorial(longint unsigned n, longint unsigned a);
      longint unsigned rest;
      longint unsigned d;
      longint unsigned e;
      if (a == 0) return 1'b0;
      if (a <= n) return 1'b1;
      rest = a;
      d = 2;
      // trial division, 2 then odd candidates
      while (d <= rest / d) begin
        if (rest % d == 0) begin
          e = 0;
          while (rest % d == 0) begin
            rest = rest / d;
            e++;
          end
          if (!prime_count_reaches(n, d, e)) return 1'b0;
        end
        d = (d == 2) ? 3 : d + 2;
      end
      // leftover prime factor
      if (rest > 1 && !prime_count_reaches(n, rest, 1)) return 1'b0;
      return 1'b1;
    endfunction

    function void note_query(logic [VB-1:0] n, logic [VB-1:0] a);
      expected_flags.push_back(divides_factorial(n, a));
    endfunction

    function void check_flag(logic flag);
      bit want;
      if (expected_flags.size() == 0) begin
        $error("divides_flag with no transaction pending: expected none, actual %0b", flag);
        failures++;
        return;
      end
      want = expected_flags.pop_front();
      if (flag !== want) begin
        $error("divides_flag mismatch: expected %0b, actual %0b", want, flag);
        failures++;
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;

  divisibility_scoreboard sb = new();

  fdt_in_if #(.VALUE_BITS(VB)) in_chan ();
  fdt_out_if out_chan ();

  factorial_divisibility_test_core #(.VALUE_BITS(VB)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // clock
  always #6 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_query(in_chan.factorial_base, in_chan.divisor_value);
      end
      if (out_chan.valid && out_chan.ready) begin
        sb.check_flag(out_chan.divides_flag);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one transaction; valid stays high across back-to-back items
  task automatic send_query(input logic [VB-1:0] n, input logic [VB-1:0] a);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.factorial_base <= n;
    in_chan.divisor_value  <= a;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // random query, mostly cheap to factor
  task automatic send_random_query();
    logic [VB-1:0]   n;
    logic [VB-1:0]   a;
    logic [VB-1:0]   t;
    longint unsigned prod;
    longint unsigned p;
    int              pick;
    int              primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    pick = $urandom_range(99);
    if (pick < 30) begin
      // full-width operands with a <= n
      n = VB'($urandom());
      a = VB'($urandom());
      if (a > n) begin
        t = a;
        a = n;
        n = t;
      end
    end else if (pick < 65) begin
      // product of small prime powers against a small n
      prod = 1;
      repeat ($urandom_range(1, 12)) begin
        p = 64'(primes[$urandom_range(0, 11)]);
        if (prod * p <= MAX_VAL) prod = prod * p;
      end
      a = VB'(prod);
      n = VB'($urandom_range(0, 80));
    end else if (pick < 92) begin
      // a just above n, moderate size
      n = VB'($urandom_range(0, 4095));
      a = n + VB'($urandom_range(1, 1 << 20));
    end else begin
      n = VB'($urandom());
      a = '0;
    end
    send_query(n, a);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 77;
    in_chan.valid = 1'b0;
    in_chan.factorial_base = '0;
    in_chan.divisor_value = '0;
    out_chan.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero divisor, divisor one, boundaries and prime powers
    send_query('0, '0);
    send_query(MAX_VAL, '0);
    send_query('0, 1);
    send_query(MAX_VAL, 1);
    send_query(1, 2);
    send_query(2, 2);
    send_query(3, 4);
    send_query(4, 8);
    send_query(5, 6);
    send_query(5, 25);
    send_query(10, 25);
    send_query(6, 49);
    send_query(14, 49);
    send_query(96, 97);
    send_query(96, 194);
    send_query(97, 194);
    send_query(10, 2310);
    send_query(12, 2310);
    send_query(30, TOP_BIT);
    send_query(32, TOP_BIT);
    send_query(MAX_VAL, MAX_VAL);
    // large prime divisor above n: longest trial division
    send_query(MAX_VAL - VB'(1), MAX_VAL);

    // random items over three idling phases
    repeat (RANDOM_PER_PHASE) send_random_query();
    send_idle_pct = 77;
    recv_idle_pct = 33;
    repeat (RANDOM_PER_PHASE) send_random_query();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_query();
    in_chan.valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
